// ===== rtl/core/ugli_pkg.sv =====
`default_nettype none

package ugli_pkg;

   localparam int VALUE_W     = 32;
   localparam int STEP_W      = 31;
   localparam int POINTS_W    = 11;
   localparam int ENTRY_W     = 10;
   localparam int REGION_W    = 2;
   localparam int CSR_INDEX_W = 2;

   // sample table size, tied to the entry_index width
   localparam int TABLE_DEPTH = 1024;

   typedef logic [REGION_W-1:0]    region_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // result regions
   localparam region_type REGION_INTERP = 2'd0;
   localparam region_type REGION_FIRST  = 2'd1;
   localparam region_type REGION_LAST   = 2'd2;

   // register indexes
   localparam csr_index_type CSR_GRID_START    = 2'd0;
   localparam csr_index_type CSR_GRID_STEP     = 2'd1;
   localparam csr_index_type CSR_POINTS_IN_USE = 2'd2;

   // register reset values
   localparam logic [VALUE_W-1:0]  GRID_START_RESET = 32'd0;
   localparam logic [STEP_W-1:0]   GRID_STEP_RESET  = 31'd65536;
   localparam logic [POINTS_W-1:0] POINTS_RESET     = 11'd1024;

endpackage

`default_nettype wire

// ===== rtl/core/ugli_if.sv =====
`default_nettype none

interface ugli_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     kind;
   logic        [ugli_pkg::ENTRY_W-1:0]      entry_index;
   logic signed [ugli_pkg::VALUE_W-1:0]      entry_value;
   logic signed [ugli_pkg::VALUE_W-1:0]      query_x;

   modport source (output valid, kind, entry_index, entry_value, query_x, input ready);
   modport sink   (input valid, kind, entry_index, entry_value, query_x, output ready);
endinterface

interface ugli_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ugli_pkg::VALUE_W-1:0] result_y;
   ugli_pkg::region_type                region;

   modport source (output valid, result_y, region, input ready);
   modport sink   (input valid, result_y, region, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/uniform_grid_linear_interpolator_unit.sv =====
`default_nettype none

// uniform grid linear interpolator
// req_chan carries one word per item: kind selects a sample write or a query.
// a write stores entry_value at entry_index in the sample ram;
// it gives no response word. indexes at or past TABLE_DEPTH are dropped.
// a query returns one rsp_chan word: result_y (saturated Q format) and region.
// a query runs the restoring divider, which produces one quotient bit a cycle over
// 32 + FRACTION_BITS bits; when interpolating it then makes two reads of the single
// ram read port, a multiply and a final round and saturate, and when clamped one
// read of the ram port. one query is in flight at a time; the next item is taken
// once the query has moved into the output register.
// a stalled rsp_chan holds the output word; a further query waits in its last
// step until the output register frees.
// csr writes go to grid_start, grid_step, points_in_use and should be made only
// while idle. reset restores the register defaults and empties the output;
// the sample ram is not cleared and must be written before it is read.
module uniform_grid_linear_interpolator_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ugli_req_if.sink                               req_chan,
   ugli_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_write_enable,
   input  wire ugli_pkg::csr_index_type           csr_index,
   input  wire logic [ugli_pkg::VALUE_W-1:0]      csr_write_data
);

   localparam int VW   = ugli_pkg::VALUE_W;
   localparam int SW   = ugli_pkg::STEP_W;
   localparam int AW   = $clog2(ugli_pkg::TABLE_DEPTH);
   localparam int QW   = VW + FRACTION_BITS;
   localparam int CNTW = $clog2(QW);
   localparam int PW   = VW + 2 + FRACTION_BITS;
   localparam int RW   = VW + 4;

   localparam logic signed [PW-1:0] ROUND_HALF =
      {{(PW-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
   localparam logic signed [RW-1:0] SAT_HI = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_LO = {{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}};

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DIVIDE   = 3'd1;
   localparam logic [2:0] ST_DECIDE   = 3'd2;
   localparam logic [2:0] ST_FETCH_HI = 3'd3;
   localparam logic [2:0] ST_WAIT_HI  = 3'd4;
   localparam logic [2:0] ST_GRAB     = 3'd5;
   localparam logic [2:0] ST_MULTIPLY = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   // control and configuration
   logic [2:0]                       state_ff, state_in;
   logic [VW-1:0]                    start_ff, start_in;
   logic [SW-1:0]                    step_ff, step_in;
   logic [ugli_pkg::POINTS_W-1:0]    points_ff, points_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [SW-1:0]                    dstep_ff, dstep_in;
   logic [QW-1:0]                    div_ff, div_in;
   logic [SW-1:0]                    rem_ff, rem_in;
   logic [CNTW-1:0]                  cnt_ff, cnt_in;
   logic                             neg_ff, neg_in;
   logic [AW-1:0]                    last_ff, last_in;
   logic [AW-1:0]                    lo_addr_ff, lo_addr_in;
   ugli_pkg::region_type             region_ff, region_in;
   logic signed [FRACTION_BITS:0]    frac_s_ff, frac_s_in;
   logic [VW-1:0]                    y0_ff, y0_in;
   logic signed [VW:0]               diff_ff, diff_in;
   logic signed [PW-1:0]             prod_ff, prod_in;
   logic [VW-1:0]                    result_ff, result_in;
   ugli_pkg::region_type             rsp_region_ff, rsp_region_in;

   logic                             req_fire;
   logic                             out_free;
   logic [VW:0]                      offset;
   logic [VW:0]                      offset_neg;
   logic [VW-1:0]                    points_wide;
   logic [VW-1:0]                    np_wide;
   logic [VW:0]                      trial;
   logic                             quot_ge;
   logic [VW-1:0]                    idx;
   logic                             clamp_first;
   logic                             clamp_last;
   logic [FRACTION_BITS:0]           frac_mag;
   logic signed [PW-1:0]             rounded;
   logic signed [PW-1:0]             shifted;
   logic signed [RW-1:0]             sum_rw;
   logic [VW-1:0]                    sat_result;

   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic                             ram_re;
   logic [AW-1:0]                    ram_raddr;
   logic [VW-1:0]                    ram_rdata;

   ugli_ram #(
      .WIDTH (VW),
      .DEPTH (ugli_pkg::TABLE_DEPTH)
   ) u_sample_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (req_chan.entry_value),
      .read_enable   (ram_re),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign ram_we    = req_fire && (req_chan.kind == ugli_pkg::KIND_WRITE)
                      && (32'(req_chan.entry_index) < 32'(ugli_pkg::TABLE_DEPTH));
   assign ram_waddr = AW'(req_chan.entry_index);

   // offset from grid start, exact in 33 bits
   assign offset      = {req_chan.query_x[VW-1], req_chan.query_x} - {start_ff[VW-1], start_ff};
   assign offset_neg  = ~offset + {{VW{1'b0}}, 1'b1};
   assign points_wide = {{(VW-ugli_pkg::POINTS_W){1'b0}}, points_ff};
   assign np_wide     = (points_wide < 32'd2) ? 32'd2 :
                        (points_wide > 32'(ugli_pkg::TABLE_DEPTH)) ?
                        32'(ugli_pkg::TABLE_DEPTH) : points_wide;

   // one restoring step a cycle
   assign trial   = {1'b0, rem_ff, div_ff[QW-1]};
   assign quot_ge = trial >= {2'b00, dstep_ff};

   assign idx         = div_ff[QW-1:FRACTION_BITS];
   assign clamp_first = neg_ff && (idx != '0);
   assign clamp_last  = !neg_ff && (idx >= 32'(last_ff));
   assign frac_mag    = {1'b0, div_ff[FRACTION_BITS-1:0]};

   // round to nearest, ties up, then floor shift
   assign rounded = prod_ff + ROUND_HALF;
   assign shifted = rounded >>> FRACTION_BITS;
   assign sum_rw  = RW'($signed(y0_ff)) + RW'(shifted);
   assign sat_result = (sum_rw > SAT_HI) ? SAT_HI[VW-1:0] :
                       (sum_rw < SAT_LO) ? SAT_LO[VW-1:0] : sum_rw[VW-1:0];

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      step_in       = step_ff;
      points_in     = points_ff;
      rsp_valid_in  = rsp_valid_ff;
      dstep_in      = dstep_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      last_in       = last_ff;
      lo_addr_in    = lo_addr_ff;
      region_in     = region_ff;
      frac_s_in     = frac_s_ff;
      y0_in         = y0_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      result_in     = result_ff;
      rsp_region_in = rsp_region_ff;
      ram_re        = 1'b0;
      ram_raddr     = lo_addr_ff;

      if (csr_write_enable) begin
         case (csr_index)
            ugli_pkg::CSR_GRID_START:    start_in  = csr_write_data;
            ugli_pkg::CSR_GRID_STEP:     step_in   = csr_write_data[SW-1:0];
            ugli_pkg::CSR_POINTS_IN_USE: points_in = csr_write_data[ugli_pkg::POINTS_W-1:0];
            default: ;
         endcase
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.kind == ugli_pkg::KIND_QUERY)) begin
               neg_in   = offset[VW];
               div_in   = {(offset[VW] ? offset_neg[VW-1:0] : offset[VW-1:0]),
                           {FRACTION_BITS{1'b0}}};
               rem_in   = '0;
               cnt_in   = CNTW'(QW - 1);
               dstep_in = (step_ff == '0) ? {{(SW-1){1'b0}}, 1'b1} : step_ff;
               last_in  = AW'(np_wide - 32'd1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = quot_ge ? SW'(trial - {2'b00, dstep_ff}) : trial[SW-1:0];
            div_in = {div_ff[QW-2:0], quot_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ram_re    = 1'b1;
            frac_s_in = neg_ff ? $signed(~frac_mag + 1'b1) : $signed(frac_mag);
            if (clamp_first) begin
               region_in = ugli_pkg::REGION_FIRST;
               ram_raddr = '0;
               state_in  = ST_GRAB;
            end else if (clamp_last) begin
               region_in = ugli_pkg::REGION_LAST;
               ram_raddr = last_ff;
               state_in  = ST_GRAB;
            end else begin
               region_in  = ugli_pkg::REGION_INTERP;
               ram_raddr  = AW'(idx);
               lo_addr_in = AW'(idx);
               state_in   = ST_FETCH_HI;
            end
         end
         ST_FETCH_HI: begin
            ram_re    = 1'b1;
            ram_raddr = lo_addr_ff + 1'b1;
            y0_in     = ram_rdata;
            state_in  = ST_WAIT_HI;
         end
         ST_WAIT_HI: begin
            diff_in  = $signed({ram_rdata[VW-1], ram_rdata}) - $signed({y0_ff[VW-1], y0_ff});
            state_in = ST_MULTIPLY;
         end
         ST_GRAB: begin
            y0_in    = ram_rdata;
            state_in = ST_FINISH;
         end
         ST_MULTIPLY: begin
            prod_in  = diff_ff * frac_s_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               result_in     = (region_ff == ugli_pkg::REGION_INTERP) ? sat_result : y0_ff;
               rsp_region_in = region_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= ugli_pkg::GRID_START_RESET;
         step_ff      <= ugli_pkg::GRID_STEP_RESET;
         points_ff    <= ugli_pkg::POINTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         step_ff      <= step_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dstep_ff      <= dstep_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      last_ff       <= last_in;
      lo_addr_ff    <= lo_addr_in;
      region_ff     <= region_in;
      frac_s_ff     <= frac_s_in;
      y0_ff         <= y0_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      result_ff     <= result_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.result_y = result_ff;
   assign rsp_chan.region   = rsp_region_ff;

   // partial remainder stays below the divisor through the whole division
   a_rem_below_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < dstep_ff))
      else $error("divider remainder not below step");

   // the upper neighbor of an interpolation never passes the last sample
   a_hi_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH_HI) |-> (lo_addr_ff < last_ff))
      else $error("interpolation neighbor beyond last sample");

   // a response word only appears out of the final step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response word without a finished query");

   // an accepted query always starts the divider
   a_query_divides: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.kind == ugli_pkg::KIND_QUERY)) |=> (state_ff == ST_DIVIDE))
      else $error("query did not start division");

endmodule

`default_nettype wire

// ===== rtl/core/ugli_ram.sv =====
`default_nettype none

module ugli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         storage_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= storage_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire
